// File: rtl/round_robin_mailbox_allocator_unit_assert.svh
// Assertion macros for the mailbox allocator checker.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ROUND_ROBIN_MAILBOX_ALLOCATOR_UNIT_ASSERT_SVH
`define ROUND_ROBIN_MAILBOX_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define RRMA_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define RRMA_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/rrma_pkg.sv
`default_nettype none

package rrma_pkg;

	localparam int MAILBOX_COUNT = 8;
	localparam int ADDRESS_BITS = 24;
	localparam int SLOT_BITS = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;

	localparam int FIELD_ADDR_BITS = 24;
	localparam int FIELD_SLOT_BITS = 3;

	typedef enum logic {
		KIND_POST = 1'b0,
		KIND_TAKE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic [FIELD_ADDR_BITS-1:0]  block_address;
		logic [FIELD_SLOT_BITS-1:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic                        accepted;
		logic [FIELD_SLOT_BITS-1:0]  slot_used;
		logic [FIELD_ADDR_BITS-1:0]  taken_address;
	} rsp_t;

endpackage

`default_nettype wire

// File: rtl/round_robin_mailbox_allocator_unit.sv
// Round robin mailbox allocator.
// Input channel (in_valid / in_stall): kind, block_address, slot_index. A post
// (kind 0) stores block_address in the first free mailbox found from the rotating
// pointer; a take (kind 1) reads and frees the mailbox named by slot_index.
// Output channel (out_valid / out_stall): accepted, slot_used, taken_address,
// one result per input transaction, in order.
// Each result passes through the input register and then the result register
// before it is presented on the output channel.
// Throughput: one transaction per cycle while out_stall is low; the free-slot search
// is a single rotating priority encoder over the busy flags, and the slot state
// updates in the same cycle the item leaves the input register.
// Reset: all mailboxes free, search pointer at slot 0, no result pending.
// Receiver stall: the result register holds its transaction; one more item can
// wait in the input register, after which in_stall is raised until out_stall drops.
`default_nettype none

module round_robin_mailbox_allocator_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  kind,
	input  wire logic [rrma_pkg::FIELD_ADDR_BITS-1:0]  block_address,
	input  wire logic [rrma_pkg::FIELD_SLOT_BITS-1:0]  slot_index,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       accepted,
	output logic [rrma_pkg::FIELD_SLOT_BITS-1:0]       slot_used,
	output logic [rrma_pkg::FIELD_ADDR_BITS-1:0]       taken_address
);
	import rrma_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	rsp_t rsp;
	logic advance;
	logic load_s1;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	rrma_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1 || advance) begin
				valid_s1 <= load_s1;
			end
			if (advance || !out_stall) begin
				valid_s2 <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1 <= '{kind: kind_t'(kind), block_address: block_address,
				slot_index: slot_index};
		end
		if (advance) begin
			rsp_s2 <= rsp;
		end
	end

	assign out_valid     = valid_s2;
	assign accepted      = rsp_s2.accepted;
	assign slot_used     = rsp_s2.slot_used;
	assign taken_address = rsp_s2.taken_address;

endmodule

`default_nettype wire

// File: rtl/rrma_pick.sv
`default_nettype none

module rrma_pick (
	input  wire logic [rrma_pkg::MAILBOX_COUNT-1:0] busy,
	input  wire logic [rrma_pkg::SLOT_BITS-1:0]     start,
	output logic                                    found,
	output logic [rrma_pkg::SLOT_BITS-1:0]          pos
);
	import rrma_pkg::*;

	logic [MAILBOX_COUNT-1:0] free;
	logic [SLOT_BITS-1:0]     lo_pos;
	logic [SLOT_BITS-1:0]     hi_pos;
	logic                     hi_any;

	assign free  = ~busy;
	assign found = |free;

	// First free slot at or above start wins; otherwise wrap to the lowest free slot.
	always_comb begin
		lo_pos = '0;
		hi_pos = '0;
		hi_any = 1'b0;
		for (int i = MAILBOX_COUNT - 1; i >= 0; i--) begin
			if (free[i]) begin
				lo_pos = SLOT_BITS'(i);
			end
			if (free[i] && (SLOT_BITS'(i) >= start)) begin
				hi_pos = SLOT_BITS'(i);
				hi_any = 1'b1;
			end
		end
	end

	assign pos = hi_any ? hi_pos : lo_pos;

endmodule

`default_nettype wire

// File: rtl/rrma_store.sv
`default_nettype none

module rrma_store (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire rrma_pkg::req_t req,
	output rrma_pkg::rsp_t     rsp
);
	import rrma_pkg::*;

	logic [MAILBOX_COUNT-1:0] busy_q;
	logic [ADDRESS_BITS-1:0]  addr_q [MAILBOX_COUNT];
	logic [SLOT_BITS-1:0]     start_q;

	logic                     found;
	logic [SLOT_BITS-1:0]     pos;
	logic [SLOT_BITS-1:0]     next_start;
	logic                     is_take;
	logic                     in_range;
	logic [SLOT_BITS-1:0]     want;

	rrma_pick u_pick (
		.busy  (busy_q),
		.start (start_q),
		.found (found),
		.pos   (pos)
	);

	assign is_take    = (req.kind == KIND_TAKE);
	assign in_range   = (int'(req.slot_index) < MAILBOX_COUNT);
	assign want       = SLOT_BITS'(req.slot_index);
	assign next_start = (pos == SLOT_BITS'(MAILBOX_COUNT - 1)) ? '0 : pos + 1'b1;

	always_comb begin
		rsp = '0;
		if (is_take) begin
			rsp.slot_used = req.slot_index;
			if (in_range) begin
				rsp.accepted      = busy_q[want];
				rsp.taken_address = FIELD_ADDR_BITS'(addr_q[want]);
			end
		end else if (found) begin
			rsp.accepted  = 1'b1;
			rsp.slot_used = FIELD_SLOT_BITS'(pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			start_q <= '0;
		end else if (fire) begin
			if (is_take) begin
				if (in_range) begin
					busy_q[want] <= 1'b0;
				end
			end else if (found) begin
				busy_q[pos] <= 1'b1;
				start_q     <= next_start;
			end
		end
	end

	// Take clears the stored address so a later take of the same slot reads zero.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (is_take) begin
				if (in_range) begin
					addr_q[want] <= '0;
				end
			end else if (found) begin
				addr_q[pos] <= ADDRESS_BITS'(req.block_address);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rrma_checker.sv
`default_nettype none

`include "round_robin_mailbox_allocator_unit_assert.svh"

module rrma_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_stall,
	input wire logic                                  kind,
	input wire logic [rrma_pkg::FIELD_ADDR_BITS-1:0]  block_address,
	input wire logic [rrma_pkg::FIELD_SLOT_BITS-1:0]  slot_index,
	input wire logic                                  out_valid,
	input wire logic                                  out_stall,
	input wire logic                                  accepted,
	input wire logic [rrma_pkg::FIELD_SLOT_BITS-1:0]  slot_used,
	input wire logic [rrma_pkg::FIELD_ADDR_BITS-1:0]  taken_address
);

	logic [1+rrma_pkg::FIELD_SLOT_BITS+rrma_pkg::FIELD_ADDR_BITS-1:0] out_word;
	logic [1+rrma_pkg::FIELD_ADDR_BITS+rrma_pkg::FIELD_SLOT_BITS-1:0] in_word;

	assign out_word = {accepted, slot_used, taken_address};
	assign in_word  = {kind, block_address, slot_index};

	// Hold a stalled result transaction.
	`RRMA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

	// Back-pressure the input only while the result side is stalled.
	`RRMA_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

	// A fresh result must trace back to an accepted input transaction.
	`RRMA_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without input transaction")

	// An accepted input payload must hold no unknown bits.
	`RRMA_ASSERT_IMP(a_in_known, in_valid && !in_stall, !$isunknown(in_word), "unknown input payload")

endmodule

bind round_robin_mailbox_allocator_unit rrma_checker u_rrma_checker (.*);

`default_nettype wire
